// ===== sv/histogram_statistics_macros.svh =====
// ----------------------------------------------------------------------------
// histogram statistics assertion macros
// shared concurrent check forms, clocked on aclk and held off during reset
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_STATISTICS_MACROS_SVH
`define HISTOGRAM_STATISTICS_MACROS_SVH

// same-cycle implication
`define HS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("histogram_statistics: same-cycle check failed");

// next-cycle implication
`define HS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("histogram_statistics: next-cycle check failed");

`endif

// ===== sv/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// widths and stream packing constants for histogram statistics
// ----------------------------------------------------------------------------
package hs_pkg;

    // sample and result field width
    localparam int SAMPLE_W = 13;
    // width of one histogram bin counter
    localparam int BIN_CNT_W = 20;
    // reset values of the extremes
    localparam logic signed [SAMPLE_W-1:0] LEAST_INIT = 13'sd4095;
    localparam logic signed [SAMPLE_W-1:0] GREATEST_INIT = -13'sd4096;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

endpackage

// ===== sv/hs_ram.sv =====
// ----------------------------------------------------------------------------
// hs_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module hs_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/histogram_statistics.sv =====
// ----------------------------------------------------------------------------
// histogram_statistics
// mean, median, mode and spread of a run of signed samples via a histogram
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata low bit up)                   | side
//  s_      | in  | tdata: sample[12:0]; tlast: last            | samples
//  m_      | out | tdata: mean, median, mode, spread (13 each) | one per run
//
//  samples: one transaction per cycle while in the run state, histogram
//  read-modify-write through a registered-read ram with forwarding from
//  the previous write
//  end of run: a drain state, a walk that reads and clears the histogram,
//  bit-serial division, then loading of the result
//  reset: a clearing pass over every bin, s_tready low meanwhile
//  m_ stalls hold the result; a new run is taken while it waits
//  VALUE_BINS must be a power of two
// ----------------------------------------------------------------------------
module histogram_statistics #(
    parameter int VALUE_BINS = 8192,
    parameter int MAX_ITEMS  = 524288
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hs_pkg::S_TDATA_W-1:0]  s_tdata,   // sample[12:0]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hs_pkg::M_TDATA_W-1:0]  m_tdata    // mean, median, mode, spread
);
    import hs_pkg::*;

    localparam int BIN_W = $clog2(VALUE_BINS);
    localparam int HALF  = VALUE_BINS / 2;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int NUM_W = SUM_W + 1;
    localparam int DEN_W = CNT_W + 1;
    localparam int CUM_W = ((CNT_W > BIN_CNT_W) ? CNT_W : BIN_CNT_W) + 1;
    localparam int DIV_CW = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_RUN, ST_DRAIN, ST_WALK, ST_DIV, ST_OUT
    } state_t;

    function automatic logic [BIN_W-1:0] bin_of(input logic signed [SAMPLE_W-1:0] s);
        logic signed [31:0] t;
        t = 32'(s) + 32'(HALF);
        return t[BIN_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] value_of(input logic [BIN_W-1:0] idx);
        logic signed [31:0] t;
        t = signed'(32'(idx)) - 32'(HALF);
        return t[SAMPLE_W-1:0];
    endfunction

    state_t state_reg;
    logic [BIN_W:0]   idx_reg;
    logic             p_valid_reg;
    logic [BIN_W-1:0] p_idx_reg;

    logic [CNT_W-1:0]          cnt_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SAMPLE_W-1:0] least_reg, greatest_reg;

    logic                 s1_valid_reg;
    logic [BIN_W-1:0]     s1_bin_reg;
    logic                 fw_valid_reg;
    logic [BIN_W-1:0]     fw_bin_reg;
    logic [BIN_CNT_W-1:0] fw_data_reg;

    logic [CUM_W-1:0]     cum_reg;
    logic                 med_found_reg;
    logic [BIN_W-1:0]     med_idx_reg;
    logic [BIN_CNT_W-1:0] top_reg;
    logic [1:0]           seen_reg;
    logic [BIN_W-1:0]     first_reg, second_reg;

    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [DIV_CW-1:0] div_cnt_reg;

    logic                 m_valid_reg;
    logic [SAMPLE_W-1:0]  mean_reg, median_reg, mode_reg, spread_reg;

    logic                 ram_we;
    logic [BIN_W-1:0]     ram_waddr, ram_raddr;
    logic [BIN_CNT_W-1:0] ram_wdata, ram_rdata;

    logic                   s_fire, take;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic [BIN_CNT_W-1:0]   s1_old;
    logic [SUM_W-1:0]       mag;
    logic [DEN_W:0]         rem_shift;
    logic [CUM_W-1:0]       cum_next;

    hs_ram #(.WIDTH(BIN_CNT_W), .DEPTH(VALUE_BINS)) u_bins (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshakes and sample decode
    assign s_tready = (state_reg == ST_RUN);
    assign s_fire   = s_tvalid && s_tready;
    assign s_sample = signed'(s_tdata[SAMPLE_W-1:0]);
    assign take     = s_fire && (cnt_reg != CNT_W'(MAX_ITEMS));
    assign s1_old   = (fw_valid_reg && fw_bin_reg == s1_bin_reg) ? fw_data_reg : ram_rdata;
    assign cum_next = cum_reg + CUM_W'(ram_rdata);
    assign mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};

    // ram port selection
    always_comb begin
        ram_raddr = (state_reg == ST_RUN) ? bin_of(s_sample) : idx_reg[BIN_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = s1_bin_reg;
        ram_wdata = s1_old + BIN_CNT_W'(1);
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg[BIN_W-1:0];
            ram_wdata = '0;
        end else if (state_reg == ST_WALK) begin
            ram_we    = p_valid_reg;
            ram_waddr = p_idx_reg;
            ram_wdata = '0;
        end else begin
            ram_we = s1_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, spread_reg, mode_reg, median_reg, mean_reg};

    // control, run state, walk and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            p_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            least_reg    <= LEAST_INIT;
            greatest_reg <= GREATEST_INIT;
            seen_reg     <= '0;
        end else begin
            // forwarding copy of this cycle's sample write
            fw_valid_reg <= s1_valid_reg && (state_reg != ST_WALK) && (state_reg != ST_CLEAR);
            fw_bin_reg   <= s1_bin_reg;
            fw_data_reg  <= s1_old + BIN_CNT_W'(1);
            s1_valid_reg <= take;
            s1_bin_reg   <= bin_of(s_sample);
            // result taken; a reload in ST_OUT keeps it valid
            if (m_valid_reg && m_tready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (BIN_W+1)'(VALUE_BINS - 1)) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    idx_reg <= '0;
                    if (take) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        sum_reg <= sum_reg + SUM_W'(s_sample);
                        if (s_sample < least_reg) least_reg <= s_sample;
                        if (s_sample > greatest_reg) greatest_reg <= s_sample;
                    end
                    if (s_fire && s_tlast) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // last sample write lands this cycle; walk reads from next
                    state_reg     <= ST_WALK;
                    cum_reg       <= '0;
                    med_found_reg <= 1'b0;
                    med_idx_reg   <= '0;
                    top_reg       <= '0;
                    seen_reg      <= '0;
                    quo_reg       <= NUM_W'({mag, 1'b0}) + NUM_W'(cnt_reg);
                    den_reg       <= {cnt_reg, 1'b0};
                    rem_reg       <= '0;
                    neg_reg       <= sum_reg[SUM_W-1];
                    div_cnt_reg   <= '0;
                end
                ST_WALK: begin
                    if (idx_reg != (BIN_W+1)'(VALUE_BINS)) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    p_valid_reg <= (idx_reg != (BIN_W+1)'(VALUE_BINS));
                    p_idx_reg   <= idx_reg[BIN_W-1:0];
                    if (p_valid_reg) begin
                        // median: first bin where the running total passes count/2
                        cum_reg <= cum_next;
                        if (!med_found_reg && cum_next > CUM_W'(cnt_reg >> 1)) begin
                            med_found_reg <= 1'b1;
                            med_idx_reg   <= p_idx_reg;
                        end
                        // mode: first and second bin at the highest count
                        if (ram_rdata > top_reg) begin
                            top_reg   <= ram_rdata;
                            first_reg <= p_idx_reg;
                            seen_reg  <= 2'd1;
                        end else if (ram_rdata == top_reg) begin
                            if (seen_reg == 2'd0) begin
                                first_reg <= p_idx_reg;
                                seen_reg  <= 2'd1;
                            end else if (seen_reg == 2'd1) begin
                                second_reg <= p_idx_reg;
                                seen_reg   <= 2'd2;
                            end
                        end
                        // last bin; the read pointer has already stopped
                        if (p_idx_reg == BIN_W'(VALUE_BINS - 1)) begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (rem_shift >= {1'b0, den_reg}) begin
                        rem_reg <= rem_shift - {1'b0, den_reg};
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CW'(NUM_W - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        mean_reg     <= neg_reg ? SAMPLE_W'(-quo_reg) : quo_reg[SAMPLE_W-1:0];
                        median_reg   <= med_found_reg ? value_of(med_idx_reg) : '0;
                        mode_reg     <= value_of((seen_reg == 2'd1) ? first_reg : second_reg);
                        spread_reg   <= SAMPLE_W'(greatest_reg - least_reg);
                        cnt_reg      <= '0;
                        sum_reg      <= '0;
                        least_reg    <= LEAST_INIT;
                        greatest_reg <= GREATEST_INIT;
                        state_reg    <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // checks
    `include "histogram_statistics_macros.svh"

    `HS_ASSERT_IMPLY(a_seen_range, 1'b1, seen_reg != 2'd3)
    `HS_ASSERT_NEXT(a_out_from_done, !m_valid_reg && state_reg != ST_OUT, !m_valid_reg)
    `HS_ASSERT_IMPLY(a_no_walk_write_clash, state_reg == ST_WALK, !s1_valid_reg)

endmodule

// ===== verif/tb_histogram_statistics.sv =====
// ----------------------------------------------------------------------------
// tb_histogram_statistics
// streams runs of signed samples into the histogram block and checks each
// mean, median, mode and spread result against a behavioral predictor
// ----------------------------------------------------------------------------
module tb_histogram_statistics;
    timeunit 1ns;
    timeprecision 1ps;
    import hs_pkg::*;

    localparam int BINS  = 8192;
    localparam int RUN_LIMIT = 524288;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] median;
        logic signed [SAMPLE_W-1:0] mode;
        logic [SAMPLE_W-1:0]        spread;
    } stats_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       has_want;
        stats_t                     want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    histogram_statistics i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    int unsigned      hist [BINS];
    int unsigned      n_seen;
    longint           acc;
    int               lo_val;
    int               hi_val;
    stats_t           stats_q [$];
    stim_row_t        rows [$];
    int               errors;
    bit               stim_done;
    bit               hold_long;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("** histogram_statistics: FAILED **");
        $finish;
    end

    function automatic void clear_stats();
        foreach (hist[i]) hist[i] = 0;
        n_seen = 0;
        acc    = 0;
        lo_val = 4095;
        hi_val = -4096;
    endfunction

    // count one sample; on the last one return the run statistics
    function automatic bit count_sample(input int s, input bit fin, output stats_t r);
        longint mag;
        longint q;
        int unsigned cum;
        int unsigned top;
        int unsigned ties;
        int unsigned seen;
        int b;
        bit got;
        r = '0;
        if (n_seen < RUN_LIMIT) begin
            b = (s + BINS / 2) % BINS;
            hist[b] = (hist[b] + 1) & 20'hFFFFF;
            n_seen++;
            acc += s;
            if (s < lo_val) lo_val = s;
            if (s > hi_val) hi_val = s;
        end
        if (!fin) return 0;
        mag = (acc < 0) ? -acc : acc;
        q = (2 * mag + n_seen) / (2 * longint'(n_seen));
        r.mean = SAMPLE_W'((acc < 0) ? -q : q);
        cum = 0;
        got = 0;
        for (int i = 0; i < BINS && !got; i++) begin
            cum += hist[i];
            if (cum > n_seen / 2) begin
                r.median = SAMPLE_W'(i - BINS / 2);
                got = 1;
            end
        end
        top = 0;
        ties = 0;
        seen = 0;
        foreach (hist[i]) if (hist[i] > top) top = hist[i];
        foreach (hist[i]) if (hist[i] == top) ties++;
        got = 0;
        for (int i = 0; i < BINS && !got; i++) begin
            if (hist[i] == top) begin
                seen++;
                if (ties == 1 || seen == 2) begin
                    r.mode = SAMPLE_W'(i - BINS / 2);
                    got = 1;
                end
            end
        end
        r.spread = SAMPLE_W'(hi_val - lo_val);
        clear_stats();
        return 1;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void add_row(input int s, input bit fin, input bit hw, input stats_t w);
        stim_row_t r;
        r.sample = SAMPLE_W'(s);
        r.last = fin;
        r.has_want = hw;
        r.want = w;
        rows.push_back(r);
    endfunction

    // directed table followed by random runs
    task automatic build_stimulus();
        int len;
        int kind;
        int base;
        add_row(0, 1, 1, '{0, 0, 0, 0});
        add_row(4095, 1, 1, '{4095, 4095, 4095, 0});
        add_row(-4096, 1, 1, '{-4096, -4096, -4096, 0});
        add_row(-4096, 0, 0, '0);
        add_row(4095, 1, 1, '{-1, 4095, 4095, 8191});
        add_row(-1, 0, 0, '0);
        add_row(-2, 1, 1, '{-2, -1, -1, 1});
        add_row(1, 0, 0, '0);
        add_row(2, 1, 1, '{2, 2, 2, 1});
        add_row(3, 0, 0, '0);
        add_row(3, 0, 0, '0);
        add_row(5, 0, 0, '0);
        add_row(5, 0, 0, '0);
        add_row(-7, 0, 0, '0);
        add_row(-7, 1, 0, '0);
        add_row(-5, 0, 0, '0);
        add_row(-4, 0, 0, '0);
        add_row(-4, 1, 1, '{-4, -4, -4, 1});
        add_row(-4096, 0, 0, '0);
        add_row(-4096, 0, 0, '0);
        add_row(-4096, 1, 1, '{-4096, -4096, -4096, 0});
        while (rows.size() < 1225) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(30, 150) : $urandom_range(1, 12);
            kind = $urandom_range(0, 3);
            base = $urandom_range(0, 8191) - 4096;
            for (int k = 0; k < len; k++) begin
                int s;
                case (kind)
                    0: s = $urandom_range(0, 8191) - 4096;
                    1: s = base + $urandom_range(0, 3) - 1;
                    2: s = ($urandom_range(0, 1) ? 4095 : -4096);
                    default: s = $urandom_range(0, 15) - 8;
                endcase
                if (s > 4095) s = 4095;
                if (s < -4096) s = -4096;
                add_row(s, k == len - 1, 0, '0);
            end
        end
    endtask

    // sender
    initial begin
        stats_t r;
        int gap;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        aresetn   = 1'b0;
        errors    = 0;
        stim_done = 0;
        clear_stats();
        build_stimulus();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) begin
            gap = gap_len();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, rows[i].sample};
            s_tlast  <= rows[i].last;
            do @(posedge aclk); while (!s_tready);
            if (count_sample(rows[i].sample, rows[i].last, r)) begin
                if (rows[i].has_want && r != rows[i].want) begin
                    $display("%0t: table row %0d expected %h actual %h", $time, i,
                             rows[i].want, r);
                    errors++;
                end
                stats_q.push_back(r);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        m_tready  = 1'b0;
        hold_long = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!hold_long && m_tvalid) begin
                hold_long = 1;
                m_tready <= 1'b0;
                repeat (3 * BINS) @(posedge aclk);
            end
            gap = gap_len();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        stats_t got;
        stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[12:0], m_tdata[25:13], m_tdata[38:26], m_tdata[51:39]};
            if (stats_q.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, m_tdata);
                errors++;
            end else begin
                want = stats_q.pop_front();
                if (got.mean !== want.mean) begin
                    $display("%0t: mean expected %0d actual %0d", $time, want.mean, got.mean);
                    errors++;
                end
                if (got.median !== want.median) begin
                    $display("%0t: median expected %0d actual %0d", $time,
                             want.median, got.median);
                    errors++;
                end
                if (got.mode !== want.mode) begin
                    $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
                    errors++;
                end
                if (got.spread !== want.spread) begin
                    $display("%0t: spread expected %0d actual %0d", $time,
                             want.spread, got.spread);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        int waited;
        wait (stim_done);
        waited = 0;
        while (stats_q.size() > 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (BINS + 200) @(posedge aclk);
        if (errors == 0 && stats_q.size() == 0) begin
            $display("** histogram_statistics: PASSED **");
        end else begin
            $display("** histogram_statistics: FAILED **");
        end
        $finish;
    end

endmodule

// ===== histogram_statistics.f =====
+incdir+sv
sv/hs_pkg.sv
sv/hs_ram.sv
sv/histogram_statistics.sv
verif/tb_histogram_statistics.sv
